// ----- design/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg: sorted priority queue shared types and constants
// Entry, item and result layouts, error codes and control struct for the cells.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int KEY_WIDTH   = 24;
  localparam int COORD_WIDTH = 10;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ERR_OK        = 2'd0,
    ERR_UNDERFLOW = 2'd1,
    ERR_OVERFLOW  = 2'd2
  } spq_err_e;

  typedef struct packed {
    logic [KEY_WIDTH-1:0]   key;
    logic [COORD_WIDTH-1:0] x;
    logic [COORD_WIDTH-1:0] y;
  } spq_entry_t;

  typedef struct packed {
    logic                   mode;
    logic [KEY_WIDTH-1:0]   entry_key;
    logic [COORD_WIDTH-1:0] entry_x;
    logic [COORD_WIDTH-1:0] entry_y;
  } spq_in_t;

  typedef struct packed {
    logic                   removed_valid;
    logic [KEY_WIDTH-1:0]   removed_key;
    logic [COORD_WIDTH-1:0] removed_x;
    logic [COORD_WIDTH-1:0] removed_y;
    logic [CNT_W-1:0]       entry_count;
    logic                   queue_empty;
    spq_err_e               error_code;
  } spq_out_t;

  typedef struct packed {
    logic       ins;
    logic       rem;
    spq_entry_t new_entry;
  } spq_cell_ctrl_t;

endpackage

// ----- design/spq_cell.sv -----
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted chain
// Holds one entry; on insert, if free or not below the new key, takes the new
// entry or its lower neighbor's; on remove takes its upper neighbor's.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic                   clk_i,
  input  spq_pkg::spq_cell_ctrl_t ctrl_i,
  input  logic                   occupied_i,
  input  logic                   left_ge_i,
  input  spq_pkg::spq_entry_t    left_entry_i,
  input  spq_pkg::spq_entry_t    right_entry_i,
  output logic                   ge_o,
  output spq_pkg::spq_entry_t    entry_o
);
  import spq_pkg::*;

  spq_entry_t entry_q, entry_d;

  // free slot or stored key not below the new key
  assign ge_o    = !occupied_i || (entry_q.key >= ctrl_i.new_entry.key);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    priority if (ctrl_i.ins && ge_o) begin
      entry_d = left_ge_i ? left_entry_i : ctrl_i.new_entry;
    end else if (ctrl_i.rem) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

// ----- design/sorted_priority_queue_top.sv -----
// ----------------------------------------------------------------------------
// sorted_priority_queue_top: sorted priority queue on a chain of cells
//
//   channel  | signals                 | handshake
//   ---------+-------------------------+-------------------------------
//   command  | start, busy, item_i     | taken when start && !busy
//   result   | done_o, result_o        | one-cycle strobe, no back-pressure
//
// One item per cycle: every cell compares its key with the broadcast key
// and shifts in parallel, so the result strobes the cycle after acceptance.
// busy stays low. Reset clears the count and the result strobe only; slot
// contents are never cleared. The receiver cannot stall.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  spq_pkg::spq_in_t  item_i,
  output logic              done_o,
  output spq_pkg::spq_out_t result_o
);
  import spq_pkg::*;

  logic             accept;
  logic             full, empty;
  logic [CNT_W-1:0] count_q, count_d;
  logic             done_q;
  spq_out_t         result_q, result_d;
  spq_cell_ctrl_t   ctrl;

  spq_entry_t       entries [QUEUE_DEPTH];
  logic             ge      [QUEUE_DEPTH];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count_q == CNT_W'(QUEUE_DEPTH));
  assign empty  = (count_q == '0);

  assign ctrl.ins       = accept && (item_i.mode == MODE_INSERT) && !full;
  assign ctrl.rem       = accept && (item_i.mode == MODE_REMOVE) && !empty;
  assign ctrl.new_entry = '{key: item_i.entry_key, x: item_i.entry_x, y: item_i.entry_y};

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic       occupied;
    logic       left_ge;
    spq_entry_t left_entry, right_entry;

    assign occupied = (CNT_W'(i) < count_q);

    if (i == 0) begin : g_first
      assign left_ge    = 1'b0;
      assign left_entry = entries[i];
    end else begin : g_mid
      assign left_ge    = ge[i-1];
      assign left_entry = entries[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_entry = entries[i];
    end else begin : g_inner
      assign right_entry = entries[i+1];
    end

    spq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .occupied_i   (occupied),
      .left_ge_i    (left_ge),
      .left_entry_i (left_entry),
      .right_entry_i(right_entry),
      .ge_o         (ge[i]),
      .entry_o      (entries[i])
    );
  end

  always_comb begin
    count_d  = count_q;
    result_d = '0;
    result_d.error_code = ERR_OK;
    priority if (ctrl.ins) begin
      count_d = count_q + CNT_W'(1);
    end else if (ctrl.rem) begin
      count_d                = count_q - CNT_W'(1);
      result_d.removed_valid = 1'b1;
      result_d.removed_key   = entries[0].key;
      result_d.removed_x     = entries[0].x;
      result_d.removed_y     = entries[0].y;
    end else if (item_i.mode == MODE_REMOVE) begin
      result_d.error_code = ERR_UNDERFLOW;
    end else begin
      result_d.error_code = ERR_OVERFLOW;
    end
    result_d.entry_count = count_d;
    result_d.queue_empty = (count_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= accept;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_q <= result_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

// ----- design/spq_checker.sv -----
// ----------------------------------------------------------------------------
// spq_port_checks: port-level checks for the sorted priority queue
// Watches the command and result ports; bound to the top level.
// ----------------------------------------------------------------------------
module spq_port_checks (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input spq_pkg::spq_out_t result_o,
  input logic              done_o
);
  import spq_pkg::*;

  a_done_follows_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> done_o)
    else $error("result strobe missing after accepted item");

  a_no_spurious_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy))
    else $error("result strobe without accepted item");

  a_empty_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.queue_empty == (result_o.entry_count == '0)))
    else $error("empty flag disagrees with count");

  a_valid_means_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.removed_valid) |-> (result_o.error_code == ERR_OK))
    else $error("removed entry reported with an error");

  a_overflow_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (result_o.error_code == ERR_OVERFLOW))
      |-> (result_o.entry_count == CNT_W'(QUEUE_DEPTH)))
    else $error("overflow reported on a queue that is not full");

endmodule

bind sorted_priority_queue_top spq_port_checks u_spq_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .result_o (result_o),
  .done_o   (done_o)
);

// ----- tb/spq_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_checker: result checker for the sorted priority queue
// Watches the command and result channels, keeps its own sorted copy of the
// queue, predicts each result and compares it field by field in order.
// ----------------------------------------------------------------------------
module spq_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic              busy,
  input  spq_pkg::spq_in_t  item_i,
  input  logic              done_o,
  input  spq_pkg::spq_out_t result_o,
  output int                fail_count,
  output int                pending,
  output int                n_checked,
  output int                n_underflow,
  output int                n_overflow,
  output int                peak_fill
);
  import spq_pkg::*;

  spq_entry_t slots [QUEUE_DEPTH];
  int         fill;
  spq_out_t   due_results [$];

  function automatic spq_out_t apply_queue_op(spq_in_t it);
    spq_out_t r;
    int       pos;
    r = '0;
    r.error_code = ERR_OK;
    if (it.mode == MODE_INSERT) begin
      if (fill >= QUEUE_DEPTH) begin
        r.error_code = ERR_OVERFLOW;
        n_overflow++;
      end else begin
        pos = 0;
        while (pos < fill && slots[pos].key < it.entry_key) pos++;
        for (int i = fill; i > pos; i--) slots[i] = slots[i-1];
        slots[pos].key = it.entry_key;
        slots[pos].x   = it.entry_x;
        slots[pos].y   = it.entry_y;
        fill++;
      end
    end else begin
      if (fill == 0) begin
        r.error_code = ERR_UNDERFLOW;
        n_underflow++;
      end else begin
        r.removed_valid = 1'b1;
        r.removed_key   = slots[0].key;
        r.removed_x     = slots[0].x;
        r.removed_y     = slots[0].y;
        for (int i = 1; i < fill; i++) slots[i-1] = slots[i];
        fill--;
      end
    end
    if (fill > peak_fill) peak_fill = fill;
    r.entry_count = CNT_W'(fill);
    r.queue_empty = (fill == 0);
    return r;
  endfunction

  function automatic void check_result(spq_out_t got);
    spq_out_t want;
    if (due_results.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("[%0t] unexpected result: key=%h x=%0d y=%0d count=%0d err=%0d", $realtime,
                 got.removed_key, got.removed_x, got.removed_y, got.entry_count,
                 got.error_code);
      return;
    end
    want = due_results.pop_front();
    n_checked++;
    if (got.removed_valid !== want.removed_valid || got.removed_key !== want.removed_key ||
        got.removed_x !== want.removed_x || got.removed_y !== want.removed_y ||
        got.entry_count !== want.entry_count || got.queue_empty !== want.queue_empty ||
        got.error_code !== want.error_code) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("[%0t] mismatch on result %0d", $realtime, n_checked);
        $display("  expected: valid=%b key=%h x=%0d y=%0d count=%0d empty=%b err=%0d",
                 want.removed_valid, want.removed_key, want.removed_x, want.removed_y,
                 want.entry_count, want.queue_empty, want.error_code);
        $display("  actual:   valid=%b key=%h x=%0d y=%0d count=%0d empty=%b err=%0d",
                 got.removed_valid, got.removed_key, got.removed_x, got.removed_y,
                 got.entry_count, got.queue_empty, got.error_code);
      end
    end
  endfunction

  initial begin
    fail_count  = 0;
    pending     = 0;
    n_checked   = 0;
    n_underflow = 0;
    n_overflow  = 0;
    peak_fill   = 0;
    fill        = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill = 0;
      due_results.delete();
    end else begin
      if (start && !busy) due_results.insert(due_results.size(), apply_queue_op(item_i));
      if (done_o) check_result(result_o);
    end
    pending = due_results.size();
  end

endmodule

// ----- tb/tb_sorted_priority_queue_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue_top: testbench for the sorted priority queue
// Sends a directed sequence (underflow, key and coordinate extremes, equal
// keys) and then random insert/remove phases that fill the queue to overflow
// and drain it to underflow, with random idle cycles outside one gap-free
// stretch. Results are checked by spq_checker.
// ----------------------------------------------------------------------------
module tb_sorted_priority_queue_top;
  import spq_pkg::*;

  localparam int N_RANDOM    = 2000;
  localparam int CYCLE_LIMIT = 50000;

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  logic     busy;
  spq_in_t  item_i;
  logic     done_o;
  spq_out_t result_o;

  int fail_count, pending, n_checked, n_underflow, n_overflow, peak_fill;
  int n_sent;
  int cycle_cnt;
  bit no_gaps;

  sorted_priority_queue_top dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .item_i   (item_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

  spq_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item_i),
    .done_o      (done_o),
    .result_o    (result_o),
    .fail_count  (fail_count),
    .pending     (pending),
    .n_checked   (n_checked),
    .n_underflow (n_underflow),
    .n_overflow  (n_overflow),
    .peak_fill   (peak_fill)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  initial cycle_cnt = 0;
  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("Verification failed");
    $finish;
  end

  function automatic spq_in_t mk_item(logic mode, logic [KEY_WIDTH-1:0] key,
                                      logic [COORD_WIDTH-1:0] x, logic [COORD_WIDTH-1:0] y);
    spq_in_t it;
    it.mode      = mode;
    it.entry_key = key;
    it.entry_x   = x;
    it.entry_y   = y;
    return it;
  endfunction

  function automatic logic [KEY_WIDTH-1:0] pick_key();
    logic [KEY_WIDTH-1:0] k;
    case ($urandom_range(0, 3))
      0: k = KEY_WIDTH'($urandom());
      1: k = KEY_WIDTH'($urandom_range(0, 7));
      2: begin
        case ($urandom_range(0, 3))
          0: k = '0;
          1: k = '1;
          2: k = {1'b1, {(KEY_WIDTH-1){1'b0}}};
          default: k = {1'b0, {(KEY_WIDTH-1){1'b1}}};
        endcase
      end
      default: k = {16'($urandom()), 8'h00};
    endcase
    return k;
  endfunction

  task automatic send_item(spq_in_t it);
    while (!no_gaps && $urandom_range(0, 99) < 23) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
    n_sent++;
  endtask

  initial begin
    int phase_len;
    int ins_pct;
    logic mode;

    start   = 1'b0;
    item_i  = '0;
    rst_ni  = 1'b0;
    n_sent  = 0;
    no_gaps = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_item(mk_item(MODE_REMOVE, '0, '0, '0));
    send_item(mk_item(MODE_INSERT, '0, '0, '0));
    send_item(mk_item(MODE_INSERT, '1, '1, '1));
    send_item(mk_item(MODE_INSERT, 24'h000100, 10'd1023, 10'd0));
    send_item(mk_item(MODE_INSERT, 24'h000100, 10'd0, 10'd1023));
    send_item(mk_item(MODE_INSERT, 24'h000100, 10'd512, 10'd511));
    send_item(mk_item(MODE_INSERT, 24'h7FFFFF, 10'd341, 10'd682));
    send_item(mk_item(MODE_INSERT, 24'h800000, 10'd682, 10'd341));
    repeat (8) send_item(mk_item(MODE_REMOVE, '1, '1, '1));
    send_item(mk_item(MODE_INSERT, '1, 10'd5, 10'd6));
    send_item(mk_item(MODE_INSERT, '1, 10'd7, 10'd8));
    send_item(mk_item(MODE_INSERT, '0, 10'd9, 10'd10));
    repeat (4) send_item(mk_item(MODE_REMOVE, '0, '0, '0));

    while (n_sent < N_RANDOM) begin
      phase_len = $urandom_range(20, 150);
      case ($urandom_range(0, 2))
        0: ins_pct = 90;
        1: ins_pct = 55;
        default: ins_pct = 15;
      endcase
      repeat (phase_len) begin
        no_gaps = (n_sent >= 900 && n_sent < 1300);
        mode = ($urandom_range(0, 99) < ins_pct) ? MODE_INSERT : MODE_REMOVE;
        send_item(mk_item(mode, pick_key(), COORD_WIDTH'($urandom_range(0, 1023)),
                          COORD_WIDTH'($urandom_range(0, 1023))));
      end
    end
    start <= 1'b0;

    wait (pending == 0);
    repeat (4) @(posedge clk_i);

    $display("Summary: %0d items sent, %0d results checked, %0d mismatches", n_sent,
             n_checked, fail_count);
    $display("Summary: %0d underflows, %0d overflows, peak fill %0d of %0d", n_underflow,
             n_overflow, peak_fill, QUEUE_DEPTH);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/spq_pkg.sv
design/spq_cell.sv
design/sorted_priority_queue_top.sv
design/spq_checker.sv
tb/spq_checker.sv
tb/tb_sorted_priority_queue_top.sv
